@@ rtl/lpad_pkg.sv @@
// Shared types, constants and the trained weight table of the linear-predictor
// anomaly detector. Used by the core and the multiply-accumulate unit of the block and by its checker.
// Depends on nothing.
package lpad_pkg;

  // Default geometry
  localparam int TapsDefault       = 25;
  localparam int SampleBitsDefault = 10;

  // Fixed field widths
  localparam int WeightW   = 16;
  localparam int WeightIdxW = 6;
  localparam int BiasW     = 17;
  localparam int ThreshW   = 19;
  localparam int ConsecW   = 8;
  localparam int PredW     = 19;
  localparam int ErrW      = 19;
  localparam int RunW      = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 19;
  localparam int RoundShift = 11;

  // Saturation limits in sixteenths of a sample LSB
  localparam int signed PredMin = -262144;
  localparam int signed PredMax = 262143;
  localparam int        ErrMax  = 524287;

  // Register reset values
  localparam logic signed [BiasW-1:0] BiasReset   = 17'sd22292;
  localparam logic [ThreshW-1:0]      ThreshReset = 19'd226;
  localparam logic [ConsecW-1:0]      ConsecReset = 8'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegBias   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegThresh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegConsec = 2'd2;

  // Verdict codes
  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_WARNING = 2'd1,
    ST_ANOMALY = 2'd2
  } status_e;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

  // Trained weights, signed Q1.15; the first one goes with the oldest sample
  function automatic logic signed [WeightW-1:0] lpad_weight(input logic [WeightIdxW-1:0] idx);
    logic signed [WeightW-1:0] w;
    case (idx)
      6'd0:  w = -16'sd2336;
      6'd1:  w = 16'sd5729;
      6'd2:  w = -16'sd2301;
      6'd3:  w = -16'sd2669;
      6'd4:  w = -16'sd3178;
      6'd5:  w = -16'sd3996;
      6'd6:  w = -16'sd2529;
      6'd7:  w = -16'sd1734;
      6'd8:  w = -16'sd10717;
      6'd9:  w = -16'sd1287;
      6'd10: w = -16'sd1794;
      6'd11: w = -16'sd13323;
      6'd12: w = -16'sd2134;
      6'd13: w = -16'sd587;
      6'd14: w = -16'sd1347;
      6'd15: w = -16'sd3339;
      6'd16: w = -16'sd936;
      6'd17: w = -16'sd1992;
      6'd18: w = 16'sd2688;
      6'd19: w = -16'sd3437;
      6'd20: w = -16'sd2551;
      6'd21: w = -16'sd441;
      6'd22: w = 16'sd3072;
      6'd23: w = -16'sd3294;
      6'd24: w = -16'sd2906;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/lpad_window.sv @@
// Ring window of past samples: one write port, one registered read port.
// Depends on nothing.
module lpad_window #(
  parameter int DEPTH = 25,
  parameter int WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write new samples
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lpad_mac.sv @@
// Shared multiply-accumulate unit: one weight times one sample per enabled cycle.
// Depends on lpad_pkg for the control struct and the weight width.
module lpad_mac #(
  parameter int SAMPLE_BITS = 10,
  parameter int ACC_W       = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lpad_pkg::mac_ctrl_t              ctrl_i,
  input  logic signed [lpad_pkg::WeightW-1:0] weight_i,
  input  logic [SAMPLE_BITS-1:0]           sample_i,
  output logic signed [ACC_W-1:0]          acc_o
);
  import lpad_pkg::*;

  localparam int ProdW = WeightW + SAMPLE_BITS + 1;

  logic signed [ProdW-1:0] prod;
  logic signed [ACC_W-1:0] acc_q;

  assign prod = weight_i * $signed({1'b0, sample_i});

  // Clear at item start, accumulate one tap per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.en) begin
      acc_q <= acc_q + ACC_W'(prod);
    end
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/linear_predictor_anomaly_detector_core.sv @@
// Top level of the linear-predictor anomaly detector: sequencer, registers,
// rounding, error and verdict. Depends on lpad_pkg, lpad_window, lpad_mac.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------------------
//   s_axis   | in        | tvalid/tready           | tdata: sample
//   m_axis   | out       | tvalid/tready           | tdata: sample_echo, predicted,
//            |           |                         |        abs_error; tuser: status
//   cfg      | in        | cfg_we_i, no wait       | cfg_idx_i, cfg_data_i
//
// The first TAPS items after reset fill the window, one per cycle, no result.
// Each later item goes through all TAPS taps on the shared multiply-
// accumulate (the window memory read is registered), then a step to round
// and add the bias, then a step to judge. The judge step waits while the
// output register is full and not being taken. Reset needs no clearing
// pass; the window is written completely before any entry is read.
module linear_predictor_anomaly_detector_core #(
  parameter int TAPS        = lpad_pkg::TapsDefault,
  parameter int SAMPLE_BITS = lpad_pkg::SampleBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // sample, zero padded to whole bytes
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  // sample_echo, predicted, abs_error, zero padded to whole bytes
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_BITS+38+7)/8)*8-1:0]     m_axis_tdata,
  // status
  output logic [1:0]                             m_axis_tuser,
  input  logic                                   cfg_we_i,
  input  logic [lpad_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [lpad_pkg::CfgDataW-1:0]          cfg_data_i
);
  import lpad_pkg::*;

  localparam int OutTdataW = ((SAMPLE_BITS + 38 + 7) / 8) * 8;
  localparam int PtrW   = $clog2(TAPS);
  localparam int CntW   = $clog2(TAPS + 1);
  localparam int AccW   = WeightW + SAMPLE_BITS + 1 + $clog2(TAPS);
  localparam int PW     = AccW + 2;
  localparam int DiffW  = ((SAMPLE_BITS + 4 > PredW) ? SAMPLE_BITS + 4 : PredW) + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_PRED  = 2'd2;
  localparam logic [1:0] S_JUDGE = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [PtrW-1:0]         oldest_q, oldest_d;
  logic [PtrW-1:0]         rd_addr_q, rd_addr_d;
  logic [CntW-1:0]         fill_q, fill_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [RunW-1:0]         run_q, run_d;
  logic                    out_valid_q, out_valid_d;

  logic signed [BiasW-1:0] bias_q;
  logic [ThreshW-1:0]      thresh_q;
  logic [ConsecW-1:0]      consec_q;

  logic [SAMPLE_BITS-1:0]  sample_q;
  logic signed [PredW-1:0] pred_q;
  logic [SAMPLE_BITS-1:0]  out_sample_q;
  logic [PredW-1:0]        out_pred_q;
  logic [ErrW-1:0]         out_err_q;
  status_e                 out_status_q, status_d;

  logic                    in_acc;
  logic                    fill_phase;
  logic                    out_free;
  logic                    judge_go;
  logic                    mem_we;
  logic [SAMPLE_BITS-1:0]  mem_wdata;
  logic [SAMPLE_BITS-1:0]  rd_data;
  logic [SAMPLE_BITS-1:0]  in_sample;
  mac_ctrl_t               mac_ctrl;
  logic signed [WeightW-1:0] weight;
  logic signed [AccW-1:0]  acc;

  logic signed [PW-1:0]    rnd;
  logic signed [PW-1:0]    shifted;
  logic signed [PW-1:0]    pred_full;
  logic signed [PredW-1:0] pred_sat;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        mag;
  logic [ErrW-1:0]         err;
  logic                    over;
  logic [RunW-1:0]         run_inc;

  assign in_sample  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign fill_phase = (fill_q < CntW'(TAPS));
  assign out_free   = !out_valid_q || m_axis_tready;
  assign judge_go   = (state_q == S_JUDGE) && out_free;

  // Window memory: fill writes on accept, judged samples at the end
  assign mem_we    = (in_acc && fill_phase) || judge_go;
  assign mem_wdata = (state_q == S_IDLE) ? in_sample : sample_q;

  lpad_window #(
    .DEPTH(TAPS),
    .WIDTH(SAMPLE_BITS)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(oldest_q),
    .wdata_i(mem_wdata),
    .raddr_i(rd_addr_q),
    .rdata_o(rd_data)
  );

  // Shared multiply-accumulate; the read data arrives in the cycle after its address
  assign mac_ctrl.clr = in_acc && !fill_phase;
  assign mac_ctrl.en  = (state_q == S_MAC) && (cnt_q != '0);
  assign weight       = lpad_weight(WeightIdxW'(cnt_q - 1'b1));

  lpad_mac #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ACC_W      (AccW)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .weight_i(weight),
    .sample_i(rd_data),
    .acc_o   (acc)
  );

  // Round to sixteenths, add bias, saturate
  always_comb begin
    rnd       = PW'(acc) + PW'(1024);
    shifted   = rnd >>> RoundShift;
    pred_full = shifted + PW'(bias_q);
    if (pred_full < PW'(PredMin)) begin
      pred_sat = PredW'(PredMin);
    end else if (pred_full > PW'(PredMax)) begin
      pred_sat = PredW'(PredMax);
    end else begin
      pred_sat = PredW'(pred_full);
    end
  end

  // Absolute error and verdict
  always_comb begin
    diff    = $signed(DiffW'({sample_q, 4'b0000})) - DiffW'(pred_q);
    mag     = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    err     = (mag > DiffW'(ErrMax)) ? ErrW'(ErrMax) : ErrW'(mag);
    over    = (err > thresh_q);
    run_inc = (run_q == '1) ? run_q : run_q + 1'b1;
    if (over) begin
      run_d    = run_inc;
      status_d = (run_inc >= consec_q) ? ST_ANOMALY : ST_WARNING;
    end else begin
      run_d    = '0;
      status_d = ST_NORMAL;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    rd_addr_d   = rd_addr_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (fill_phase) begin
            oldest_d = (oldest_q == PtrW'(TAPS - 1)) ? '0 : oldest_q + 1'b1;
            fill_d   = fill_q + 1'b1;
          end else begin
            rd_addr_d = oldest_q;
            cnt_d     = '0;
            state_d   = S_MAC;
          end
        end
      end
      S_MAC: begin
        rd_addr_d = (rd_addr_q == PtrW'(TAPS - 1)) ? '0 : rd_addr_q + 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CntW'(TAPS)) begin
          state_d = S_PRED;
        end
      end
      S_PRED: begin
        state_d = S_JUDGE;
      end
      S_JUDGE: begin
        if (out_free) begin
          oldest_d    = (oldest_q == PtrW'(TAPS - 1)) ? '0 : oldest_q + 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oldest_q    <= '0;
      rd_addr_q   <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      rd_addr_q   <= rd_addr_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (judge_go) begin
        run_q <= run_d;
      end
    end
  end

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q   <= BiasReset;
      thresh_q <= ThreshReset;
      consec_q <= ConsecReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBias:   bias_q   <= $signed(cfg_data_i[BiasW-1:0]);
        RegThresh: thresh_q <= cfg_data_i[ThreshW-1:0];
        RegConsec: consec_q <= cfg_data_i[ConsecW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_sample;
    end
    if (state_q == S_PRED) begin
      pred_q <= pred_sat;
    end
    if (judge_go) begin
      out_sample_q <= sample_q;
      out_pred_q   <= pred_q;
      out_err_q    <= err;
      out_status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'({out_err_q, out_pred_q, out_sample_q});
  assign m_axis_tuser  = out_status_q;

endmodule

@@ rtl/lpad_checker.sv @@
// Port-level checker of the linear-predictor anomaly detector and its bind.
// Depends on lpad_pkg and on the ports of linear_predictor_anomaly_detector_core.
module lpad_checker #(
  parameter int SAMPLE_BITS = lpad_pkg::SampleBitsDefault
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((SAMPLE_BITS+38+7)/8)*8-1:0] m_axis_tdata,
  input logic [1:0]                          m_axis_tuser,
  input logic                                cfg_we_i,
  input logic [lpad_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input logic [lpad_pkg::CfgDataW-1:0]       cfg_data_i
);
  import lpad_pkg::*;

  localparam int DiffW = ((SAMPLE_BITS + 4 > PredW) ? SAMPLE_BITS + 4 : PredW) + 2;

  logic [ThreshW-1:0]      thresh_q;
  logic [SAMPLE_BITS-1:0]  echo;
  logic signed [PredW-1:0] pred;
  logic [ErrW-1:0]         err;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        mag;
  logic [ErrW-1:0]         err_exp;

  // Mirror the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i && cfg_idx_i == RegThresh) begin
      thresh_q <= cfg_data_i[ThreshW-1:0];
    end
  end

  // Recompute the error from the echoed sample and the prediction
  always_comb begin
    echo    = m_axis_tdata[SAMPLE_BITS-1:0];
    pred    = $signed(m_axis_tdata[SAMPLE_BITS+PredW-1:SAMPLE_BITS]);
    err     = m_axis_tdata[SAMPLE_BITS+PredW+ErrW-1:SAMPLE_BITS+PredW];
    diff    = $signed(DiffW'({echo, 4'b0000})) - DiffW'(pred);
    mag     = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    err_exp = (mag > DiffW'(ErrMax)) ? ErrW'(ErrMax) : ErrW'(mag);
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_err_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> err == err_exp)
    else $error("abs_error does not match sample and prediction");

  a_normal_thresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == ST_NORMAL) == (err <= thresh_q)))
    else $error("status disagrees with threshold");

endmodule

bind linear_predictor_anomaly_detector_core lpad_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_lpad_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i)
);

@@ sim/tb_linear_predictor_anomaly_detector_core.sv @@
// Self-checking bench for the linear-predictor anomaly detector: a ring-window
// predictor mirrors the block and judges every sample past the window fill, in order.
// Depends on lpad_pkg and linear_predictor_anomaly_detector_core.
module tb_linear_predictor_anomaly_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lpad_pkg::*;

  localparam int Taps          = TapsDefault;
  localparam int SampleBits    = SampleBitsDefault;
  localparam int SDataW        = ((SampleBits + 7) / 8) * 8;
  localparam int MDataW        = ((SampleBits + PredW + ErrW + 7) / 8) * 8;
  localparam int PredLsb       = SampleBits;
  localparam int ErrLsb        = SampleBits + PredW;
  localparam int ClkPeriod     = 10;
  localparam int SettleCycles  = 40;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int RunMax        = (1 << RunW) - 1;

  localparam logic [CfgIdxW-1:0] RegSpare  = 2'd3;
  localparam logic [BiasW-1:0]   BiasLow   = {1'b1, {(BiasW-1){1'b0}}};
  localparam logic [BiasW-1:0]   BiasHigh  = {1'b0, {(BiasW-1){1'b1}}};
  localparam logic [ThreshW-1:0] ThreshMax = '1;
  localparam logic [ConsecW-1:0] ConsecMax = '1;

  // Q1.15 taps, first one on the oldest sample
  localparam int TapWeight [Taps] = '{
    -2336, 5729, -2301, -2669, -3178,
    -3996, -2529, -1734, -10717, -1287,
    -1794, -13323, -2134, -587, -1347,
    -3339, -936, -1992, 2688, -3437,
    -2551, -441, 3072, -3294, -2906
  };

  typedef struct {
    logic [SampleBits-1:0]   echo;
    logic signed [PredW-1:0] pred;
    logic [ErrW-1:0]         err;
    status_e                 verdict;
  } judgement_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SDataW-1:0]      s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [MDataW-1:0]      m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [CfgDataW-1:0]    cfg_data_i = '0;

  // Mirror of the detector state and registers
  logic [SampleBits-1:0]   sample_ring [Taps];
  int unsigned             ring_oldest = 0;
  int unsigned             ring_filled = 0;
  int unsigned             over_run = 0;
  logic signed [BiasW-1:0] bias_reg = BiasReset;
  logic [ThreshW-1:0]      thresh_reg = ThreshReset;
  logic [ConsecW-1:0]      consec_reg = ConsecReset;

  judgement_t  pending_judgements[$];
  judgement_t  oldest_judgement;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  linear_predictor_anomaly_detector_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [9:0] sample
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [9:0] sample_echo, [28:10] predicted, [47:29] abs_error
    .m_axis_tuser  (m_axis_tuser),   // [1:0] status
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // Drive result ready: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // Compare each result with the oldest pending judgement
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_judgements.size() == 0) begin
        $display("%0t: unexpected result, expected none, got sample %0d", $time,
                 m_axis_tdata[SampleBits-1:0]);
        mismatch_count++;
      end else begin
        oldest_judgement = pending_judgements.pop_front();
        if (m_axis_tdata[SampleBits-1:0] !== oldest_judgement.echo)
          report_mismatch("sample_echo", longint'(oldest_judgement.echo),
                          longint'(m_axis_tdata[SampleBits-1:0]));
        if (m_axis_tdata[PredLsb +: PredW] !== oldest_judgement.pred)
          report_mismatch("predicted", longint'(oldest_judgement.pred),
                          longint'($signed(m_axis_tdata[PredLsb +: PredW])));
        if (m_axis_tdata[ErrLsb +: ErrW] !== oldest_judgement.err)
          report_mismatch("abs_error", longint'(oldest_judgement.err),
                          longint'(m_axis_tdata[ErrLsb +: ErrW]));
        if (m_axis_tuser !== oldest_judgement.verdict)
          report_mismatch("status", longint'(oldest_judgement.verdict),
                          longint'(m_axis_tuser));
      end
    end
  end

  // Prediction and error for a sample against the current window
  function automatic void predict_sample(input logic [SampleBits-1:0] smp,
                                         output logic signed [PredW-1:0] pred,
                                         output logic [ErrW-1:0] err);
    longint acc;
    longint p;
    longint d;
    int     k;
    acc = 0;
    for (k = 0; k < Taps; k++)
      acc += longint'(TapWeight[k]) * longint'(sample_ring[(ring_oldest + k) % Taps]);
    p = longint'(bias_reg) + ((acc + (longint'(1) << (RoundShift - 1))) >>> RoundShift);
    if (p < PredMin) p = PredMin;
    if (p > PredMax) p = PredMax;
    d = longint'(smp) * 16 - p;
    if (d < 0) d = -d;
    if (d > ErrMax) d = ErrMax;
    pred = p[PredW-1:0];
    err  = d[ErrW-1:0];
  endfunction

  // Mostly samples near the prediction or anywhere, some at the rails
  function automatic logic [SampleBits-1:0] pick_sample();
    logic signed [PredW-1:0] p;
    logic [ErrW-1:0]         e;
    int                      centre;
    predict_sample('0, p, e);
    case ($urandom_range(9))
      0: return $urandom_range(1) ? '1 : '0;
      1, 2, 3, 4: begin
        centre = (int'(p) + 8) / 16 + int'($urandom_range(12)) - 6;
        if (centre < 0) centre = 0;
        if (centre > (1 << SampleBits) - 1) centre = (1 << SampleBits) - 1;
        return SampleBits'(centre);
      end
      default: return SampleBits'($urandom);
    endcase
  endfunction

  // Offer one sample, then mirror its effect once it is taken
  task automatic send_sample(input logic [SampleBits-1:0] smp);
    judgement_t j;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= SDataW'(smp);
    do @(posedge clk_i); while (!s_axis_tready);
    if (ring_filled < Taps) begin
      ring_filled++;
    end else begin
      predict_sample(smp, j.pred, j.err);
      j.echo = smp;
      if (j.err > thresh_reg) begin
        if (over_run < RunMax) over_run++;
        j.verdict = (over_run >= consec_reg) ? ST_ANOMALY : ST_WARNING;
      end else begin
        over_run  = 0;
        j.verdict = ST_NORMAL;
      end
      pending_judgements.push_back(j);
    end
    sample_ring[ring_oldest] = smp;
    ring_oldest = (ring_oldest + 1) % Taps;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_judgements.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Raise a write for this edge; the caller lowers the enable afterwards
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      RegBias:   bias_reg   = val[BiasW-1:0];
      RegThresh: thresh_reg = val[ThreshW-1:0];
      RegConsec: consec_reg = val[ConsecW-1:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise; the block must ignore them
  task automatic apply_config(input logic [BiasW-1:0] b, input logic [ThreshW-1:0] t,
                              input logic [ConsecW-1:0] c);
    logic [CfgDataW-1:0] v;
    wait_idle();
    v = CfgDataW'($urandom);
    v[BiasW-1:0] = b;
    write_reg(RegBias, v);
    write_reg(RegThresh, CfgDataW'(t));
    v = CfgDataW'($urandom);
    v[ConsecW-1:0] = c;
    write_reg(RegConsec, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Fill the window with rail, checkerboard and random values, then judge extremes
  task automatic test_fill_and_extremes();
    int i;
    for (i = 0; i < Taps; i++) begin
      case (i % 4)
        0: send_sample('0);
        1: send_sample('1);
        2: send_sample(10'h2AA);
        default: send_sample(SampleBits'($urandom));
      endcase
    end
    send_sample('0);
    send_sample('1);
    send_sample(10'h155);
    send_sample(10'h2AA);
    send_sample(10'd1);
    send_sample(pick_sample());
    wait_idle();
  endtask

  // Spare index, error equal to threshold, zero and maximum run lengths
  task automatic test_register_edges();
    logic signed [PredW-1:0] p;
    logic [ErrW-1:0]         e;
    logic [SampleBits-1:0]   s;
    wait_idle();
    write_reg(RegSpare, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_sample(SampleBits'($urandom));
    // error exactly at the threshold is not over it
    s = pick_sample();
    predict_sample(s, p, e);
    apply_config(bias_reg, e, 8'd1);
    send_sample(s);
    // one above the threshold trips a single-item run
    s = SampleBits'($urandom);
    predict_sample(s, p, e);
    apply_config(bias_reg, (e == 0) ? '0 : e - 1'b1, 8'd1);
    send_sample(s);
    // zero run length: every over-threshold item is an anomaly
    apply_config(BiasLow, '0, '0);
    repeat (3) send_sample(SampleBits'($urandom));
    apply_config(BiasHigh, ThreshMax, ConsecMax);
    repeat (3) send_sample(SampleBits'($urandom));
    apply_config(BiasReset, ThreshReset, ConsecReset);
    repeat (4) send_sample(SampleBits'($urandom));
    wait_idle();
  endtask

  // Random settings, each followed by a burst of samples
  task automatic test_random_traffic(input int bursts);
    logic [BiasW-1:0]   b;
    logic [ThreshW-1:0] t;
    logic [ConsecW-1:0] c;
    int                 n;
    repeat (bursts) begin
      case ($urandom_range(5))
        0: b = BiasLow;
        1: b = BiasHigh;
        2: b = BiasW'($urandom);
        default: b = BiasW'($urandom_range(12000, 30000));
      endcase
      case ($urandom_range(7))
        0: t = ThreshW'($urandom);
        1: t = '0;
        default: t = ThreshW'($urandom_range(16, 1200));
      endcase
      case ($urandom_range(7))
        0: c = '0;
        1: c = ConsecMax;
        2: c = ConsecW'($urandom);
        default: c = ConsecW'($urandom_range(1, 5));
      endcase
      apply_config(b, t, c);
      for (n = 0; n < 25; n++) begin
        if ($urandom_range(39) == 0) wait_idle();
        send_sample(pick_sample());
      end
    end
    wait_idle();
  endtask

  // Hold the result side off while samples keep coming
  task automatic test_backpressure();
    hold_token = hold_token + 1;
    repeat (12) send_sample(pick_sample());
    wait_idle();
  endtask

  // Every item over a zero threshold: run counter must stick at its top
  task automatic test_run_saturation();
    apply_config(BiasLow, '0, ConsecMax);
    repeat (RunMax + 15) send_sample(SampleBits'($urandom));
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 63;
    test_fill_and_extremes();
    test_register_edges();
    test_random_traffic(3);

    send_idle_pct = 63;
    recv_idle_pct = 16;
    test_random_traffic(3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(3);
    test_backpressure();
    test_run_saturation();

    wait_idle();
    if (mismatch_count == 0 && pending_judgements.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
